/* hw/rtl/bbc_pkg.sv */
// bbc_pkg: shared types, codes and the closer lookup for the bracket balance checker
// depends on nothing; used by bbc_front, bbc_back and bracket_balance_checker

package bbc_pkg;

  // bracket characters
  localparam logic [7:0] ChSqOpen  = 8'h5B;  // '['
  localparam logic [7:0] ChSqClose = 8'h5D;  // ']'
  localparam logic [7:0] ChCuOpen  = 8'h7B;  // '{'
  localparam logic [7:0] ChCuClose = 8'h7D;  // '}'
  localparam logic [7:0] ChRdOpen  = 8'h28;  // '('
  localparam logic [7:0] ChRdClose = 8'h29;  // ')'

  // result error codes
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_MISMATCH = 3'd1,
    ERR_EMPTY    = 3'd2,
    ERR_UNCLOSED = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_e;

  // input word
  typedef struct packed {
    logic [7:0] ch;
    logic       char_present;
    logic       last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic       valid_res;
    logic [2:0] error_code;
  } out_word_t;

  // classified word passed from front to back
  typedef struct packed {
    logic       present;   // carries a byte
    logic       is_close;  // byte is a closing bracket
    logic [7:0] val;       // byte to push, or opener wanted by a closer
    logic       last;      // final word of the string
  } cls_t;

  // matching opener for a closer, zero when the byte is no closer
  function automatic logic [7:0] opener_for(input logic [7:0] c);
    logic [7:0] res;
    res = 8'h00;
    case (c)
      ChSqClose: res = ChSqOpen;
      ChCuClose: res = ChCuOpen;
      ChRdClose: res = ChRdOpen;
      default:   res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/bbc_front.sv */
// bbc_front: accepts input words, classifies each byte and holds them in a two-entry queue
// depends on bbc_pkg

module bbc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bbc_pkg::in_word_t in_data_i,
  output logic              hd_vld_o,
  output bbc_pkg::cls_t     hd_word_o,
  input  logic              hd_pop_i
);

  bbc_pkg::cls_t ent_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;
  bbc_pkg::cls_t cls;
  logic [7:0]    want;

  // classify the incoming byte
  always_comb begin
    want         = bbc_pkg::opener_for(in_data_i.ch);
    cls.present  = in_data_i.char_present;
    cls.is_close = (want != 8'h00);
    cls.val      = (want != 8'h00) ? want : in_data_i.ch;
    cls.last     = in_data_i.last;
  end

  // queue pointers and fill count
  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = hd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !hd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && hd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cls;
    end
  end

  assign hd_vld_o  = (cnt_q != 2'd0);
  assign hd_word_o = ent_q[rd_ptr_q];

endmodule

/* hw/rtl/bbc_back.sv */
// bbc_back: runs the bracket stack one word per cycle unless a last word waits, and registers the result word
// depends on bbc_pkg; fed by bbc_front

module bbc_back #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               hd_vld_i,
  input  bbc_pkg::cls_t      hd_word_i,
  output logic               hd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bbc_pkg::out_word_t out_data_o
);

  localparam int unsigned AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

  logic [7:0]         stack_mem [STACK_DEPTH];
  logic [LW-1:0]      level_q, level_d;
  logic [7:0]         top_q, top_d;
  logic [7:0]         below_q;
  bbc_pkg::err_e      failed_q, failed_d;
  bbc_pkg::err_e      fail_n, code;
  logic [LW-1:0]      lvl_n;
  logic [LW-1:0]      rd_lvl;
  logic [AW-1:0]      rd_idx, wr_idx;
  logic               we;
  logic               out_ready;
  logic               res_load;
  logic               out_valid_q, out_valid_d;
  bbc_pkg::out_word_t out_q, out_d;

  // the output register frees up when empty or when its word is taken
  assign out_ready = !out_valid_q || !out_stall_i;
  assign hd_pop_o  = hd_vld_i && (!hd_word_i.last || out_ready);

  // stack step for the word at the head of the queue
  always_comb begin
    fail_n   = failed_q;
    lvl_n    = level_q;
    top_d    = top_q;
    we       = 1'b0;
    if (hd_pop_o && hd_word_i.present && (failed_q == bbc_pkg::ERR_OK)) begin
      if (hd_word_i.is_close) begin
        if (level_q == '0) begin
          fail_n = bbc_pkg::ERR_EMPTY;
        end else if (top_q != hd_word_i.val) begin
          fail_n = bbc_pkg::ERR_MISMATCH;
        end else begin
          lvl_n = level_q - LW'(1);
          top_d = below_q;
        end
      end else begin
        if (level_q == LW'(STACK_DEPTH)) begin
          fail_n = bbc_pkg::ERR_OVERFLOW;
        end else begin
          we    = 1'b1;
          lvl_n = level_q + LW'(1);
          top_d = hd_word_i.val;
        end
      end
    end

    // result and end-of-string clear
    if (fail_n != bbc_pkg::ERR_OK) begin
      code = fail_n;
    end else if (lvl_n != '0) begin
      code = bbc_pkg::ERR_UNCLOSED;
    end else begin
      code = bbc_pkg::ERR_OK;
    end
    res_load = hd_pop_o && hd_word_i.last;
    if (res_load) begin
      level_d  = '0;
      failed_d = bbc_pkg::ERR_OK;
    end else begin
      level_d  = lvl_n;
      failed_d = fail_n;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_load) begin
      out_valid_d          = 1'b1;
      out_d.valid_res      = (code == bbc_pkg::ERR_OK);
      out_d.error_code     = code;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // entry just below the top is prefetched for the next pop
  assign rd_lvl = level_d - LW'(2);
  assign rd_idx = rd_lvl[AW-1:0];
  assign wr_idx = level_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[wr_idx] <= hd_word_i.val;
    end
    below_q <= stack_mem[rd_idx];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      failed_q    <= bbc_pkg::ERR_OK;
      out_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/bracket_balance_checker.sv */
// bracket_balance_checker: top level joining the classifying front and the stack back end
// depends on bbc_pkg, bbc_front and bbc_back
//
// usage: a string enters one byte per word on the input channel (ch, char_present, last).
// a word is taken at a clock edge with in_valid_i high and in_stall_o low; a word with
// char_present low carries no byte, so a lone such word with last high is an empty string.
// only the word marked last yields a result word on the output channel: valid_res and
// error_code (ok, mismatched closer, closer on empty stack, unclosed openers, overflow).
// throughput: one input word per cycle unless a last word waits on a held result; the stack
// engine does one push or pop a cycle on the same terms, with the entry under the top
// prefetched from the stack memory (one write port and one registered read port).
// result path: the last word lands in the two-entry input queue at the accepting edge, and
// the stack engine then loads the output register from the queue head, once that register
// is free.
// when the receiver stalls, the result stays in the output register and non-last words
// keep flowing; a last word waits in the queue, which then fills and raises in_stall_o.
// reset clears the queue, the stack level, the sticky error and the output valid; the stack
// memory itself is not cleared, since only entries below the level are ever used.

module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bbc_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bbc_pkg::out_word_t out_data_o
);

  logic          hd_vld;
  logic          hd_pop;
  bbc_pkg::cls_t hd_word;

  // front: classify and queue
  bbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .hd_vld_o   (hd_vld),
    .hd_word_o  (hd_word),
    .hd_pop_i   (hd_pop)
  );

  // back: stack engine and result register
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hd_vld_i    (hd_vld),
    .hd_word_i   (hd_word),
    .hd_pop_o    (hd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // the back end only takes a word the queue holds
  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hd_pop |-> hd_vld)
    else $error("queue popped while empty");

  // valid_res agrees with the error code
  a_res_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.valid_res ==
                     (out_data_o.error_code == bbc_pkg::ERR_OK)))
    else $error("valid_res disagrees with error_code");

  // a last word is never taken while the result register is held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hd_pop && hd_word.last) |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule
